FILE: hdl/midi_voice_allocator_unit_macros.svh
// Assertion macros of the voice allocator, used by the voice sequencer mva_back.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MIDI_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MVA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mva_pkg.sv
// Shared types and constants of the MIDI voice allocator.
// No dependencies; every module of the block imports this package.
package mva_pkg;

  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_MASK     = 8'hF0;

  localparam logic       CFG_ALLOC_MODE  = 1'b0;
  localparam logic       CFG_VOICE_MASK  = 1'b1;

  localparam logic [3:0] NO_VOICE        = 4'hF;
  localparam int         Q_DEPTH         = 4;

  typedef enum logic [1:0] {
    MODE_SATURATE  = 2'd0,
    MODE_STEAL     = 2'd1,
    MODE_MONO_LOW  = 2'd2,
    MODE_MONO_HIGH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_ON      = 2'd0,
    ACT_REVOICE = 2'd1,
    ACT_RETUNE  = 2'd2,
    ACT_OFF     = 2'd3
  } act_t;

  typedef logic [3:0] vid_t;

  typedef struct packed {
    logic       note_on;
    logic [6:0] note;
    logic [6:0] vel;
  } cmd_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] mask;
  } cfg_t;

endpackage

FILE: hdl/mva_if.sv
// Valid/ready channel interfaces of the voice allocator: MIDI messages in,
// voice commands out. No dependencies.
interface mva_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [6:0] second_byte;
  logic [6:0] third_byte;
  logic [2:0] byte_count;

  modport source (output valid, first_byte, second_byte, third_byte, byte_count,
                  input ready);
  modport sink (input valid, first_byte, second_byte, third_byte, byte_count,
                output ready);
endinterface

interface mva_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] voice_index;
  logic [1:0] voice_action;
  logic [6:0] note_number;
  logic [6:0] velocity;
  logic       last_command;

  modport source (output valid, voice_index, voice_action, note_number, velocity,
                  last_command, input ready);
  modport sink (input valid, voice_index, voice_action, note_number, velocity,
                last_command, output ready);
endinterface

FILE: hdl/mva_front.sv
// Message classifier: keeps the running status and turns note messages into
// commands for the queue. Depends on mva_pkg and mva_in_if.
module mva_front (
  input  logic          clk,
  input  logic          rst_n,
  mva_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output mva_pkg::cmd_t q_cmd
);
  import mva_pkg::*;

  logic [3:0] rs_r;
  logic [3:0] rs_nxt;
  logic       acc;
  logic [7:0] hi4;
  logic [7:0] rs8;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign hi4         = in_ch.first_byte & STATUS_MASK;
  assign rs8         = {rs_r, 4'h0};

  always_comb begin
    rs_nxt  = rs_r;
    q_push  = 1'b0;
    q_cmd   = '0;
    if (hi4 == STATUS_NOTE_ON && in_ch.byte_count == 3'd3) begin
      rs_nxt        = STATUS_NOTE_ON[7:4];
      q_push        = acc;
      q_cmd.note_on = (in_ch.third_byte != 7'd0);
      q_cmd.note    = in_ch.second_byte;
      q_cmd.vel     = in_ch.third_byte;
    end else if (hi4 == STATUS_NOTE_OFF && in_ch.byte_count == 3'd3) begin
      rs_nxt     = STATUS_NOTE_OFF[7:4];
      q_push     = acc;
      q_cmd.note = in_ch.second_byte;
      q_cmd.vel  = in_ch.third_byte;
    end else if (in_ch.first_byte[7]) begin
      rs_nxt = hi4[7:4];
    end else if (in_ch.byte_count == 3'd2) begin
      q_cmd.note = in_ch.first_byte[6:0];
      q_cmd.vel  = in_ch.second_byte;
      if (rs8 == STATUS_NOTE_ON && in_ch.second_byte != 7'd0) begin
        q_push        = acc;
        q_cmd.note_on = 1'b1;
      end else if (rs8 == STATUS_NOTE_ON || rs8 == STATUS_NOTE_OFF) begin
        q_push = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= 4'h0;
    end else if (acc) begin
      rs_r <= rs_nxt;
    end
  end

endmodule

FILE: hdl/mva_queue.sv
// Short command queue between the classifier and the voice sequencer.
// Depends on mva_pkg.
module mva_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mva_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output mva_pkg::cmd_t head
);
  import mva_pkg::*;

  localparam int QAW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  cmd_t           slot_r [Q_DEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QCW-1:0] cnt_r;
  logic           do_pop;

  assign full   = (cnt_r == QCW'(Q_DEPTH));
  assign valid  = (cnt_r != '0);
  assign head   = slot_r[rp_r];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/mva_back.sv
// Voice sequencer: note stack in a single-port-read memory, voice marks in flops,
// and the output register. Depends on mva_pkg, mva_out_if and the macro header.
`include "midi_voice_allocator_unit_macros.svh"

module mva_back #(
  parameter int NUM_VOICES,
  parameter int STACK_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mva_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  mva_pkg::cmd_t q_cmd,
  output logic          q_pop,
  mva_out_if.source     out_ch
);
  import mva_pkg::*;

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_SCAN    = 16'h0002,
    ST_REM     = 16'h0004,
    ST_PUSH    = 16'h0008,
    ST_EMIT    = 16'h0010,
    ST_STL_RD  = 16'h0020,
    ST_STL_CHK = 16'h0040,
    ST_POFF    = 16'h0080,
    ST_POFF_S  = 16'h0100,
    ST_POFF_RM = 16'h0200,
    ST_MON1    = 16'h0400,
    ST_MON2    = 16'h0800,
    ST_MOFF1   = 16'h1000,
    ST_MOFF2   = 16'h2000,
    ST_MOFF3   = 16'h4000,
    ST_MOFF4   = 16'h8000
  } st_t;

  st_t state_r, state_nxt, ret_r, ret_nxt;

  logic [6:0]    n_r, n_nxt, vel_r, vel_nxt, tgt_r, tgt_nxt, cur_r, cur_nxt;
  vid_t          cmpv_r, cmpv_nxt, mv_r, mv_nxt, push_v_r, push_v_nxt;
  logic [6:0]    push_n_r, push_n_nxt;
  logic [CW-1:0] count_r, count_nxt, rem_idx_r, rem_idx_nxt;
  logic [CW-1:0] sh_r, sh_nxt, rp_r, rp_nxt, sp_r, sp_nxt;
  logic          pend_r, pend_nxt, pv_r, pv_nxt;
  logic [AW-1:0] pa_r, pa_nxt, pidx_r, pidx_nxt;
  logic          fn_r, fn_nxt, fnv_r, fnv_nxt;
  logic [AW-1:0] fidx_r, fidx_nxt, fvidx_r, fvidx_nxt;
  logic [6:0]    mn_r, mn_nxt, mx_r, mx_nxt;
  vid_t          em_v_r, em_v_nxt;
  act_t          em_act_r, em_act_nxt;
  logic [6:0]    em_note_r, em_note_nxt, em_vel_r, em_vel_nxt;
  logic          em_last_r, em_last_nxt;

  logic          out_v_r;
  vid_t          out_v_idx_r;
  act_t          out_act_r;
  logic [6:0]    out_note_r, out_vel_r;
  logic          out_last_r;
  logic          out_ld;

  logic [10:0]   mem [STACK_DEPTH];
  logic [10:0]   rd_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [10:0]   mem_wd;

  logic [NUM_VOICES-1:0] taken_r;
  logic [6:0]            vnote_r [NUM_VOICES];
  logic                  vwt_en, vwn_en, vw_taken;
  vid_t                  vw_v;
  logic [6:0]            vw_note;

  logic [15:0]           mask_ext;
  logic [NUM_VOICES-1:0] en, match;
  logic                  free_found, any_en, m_found, m_more;
  vid_t                  free_idx, hi_en, m_idx;
  logic                  hi_mode, poly_mode;
  logic [6:0]            ext;
  logic [6:0]            rd_note;
  logic [3:0]            rd_voice;

  assign mask_ext  = {8'h00, cfg.mask};
  assign hi_mode   = (cfg.mode == MODE_MONO_HIGH);
  assign poly_mode = (cfg.mode == MODE_SATURATE) || (cfg.mode == MODE_STEAL);
  assign ext       = hi_mode ? mx_r : mn_r;
  assign rd_note   = rd_q[10:4];
  assign rd_voice  = rd_q[3:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    any_en     = 1'b0;
    hi_en      = '0;
    m_found    = 1'b0;
    m_more     = 1'b0;
    m_idx      = '0;
    for (int c = 0; c < NUM_VOICES; c++) begin
      en[c]    = mask_ext[c];
      match[c] = en[c] && taken_r[c] && (vnote_r[c] == n_r);
      if (!free_found && en[c] && !taken_r[c]) begin
        free_found = 1'b1;
        free_idx   = vid_t'(c);
      end
      if (en[c]) begin
        any_en = 1'b1;
        hi_en  = vid_t'(c);
      end
      if (match[c]) begin
        if (m_found) begin
          m_more = 1'b1;
        end else begin
          m_found = 1'b1;
          m_idx   = vid_t'(c);
        end
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    n_nxt       = n_r;
    vel_nxt     = vel_r;
    tgt_nxt     = tgt_r;
    cur_nxt     = cur_r;
    cmpv_nxt    = cmpv_r;
    mv_nxt      = mv_r;
    push_n_nxt  = push_n_r;
    push_v_nxt  = push_v_r;
    count_nxt   = count_r;
    rem_idx_nxt = rem_idx_r;
    sh_nxt      = sh_r;
    rp_nxt      = rp_r;
    sp_nxt      = sp_r;
    pend_nxt    = pend_r;
    pa_nxt      = pa_r;
    pv_nxt      = pv_r;
    pidx_nxt    = pidx_r;
    fn_nxt      = fn_r;
    fidx_nxt    = fidx_r;
    fnv_nxt     = fnv_r;
    fvidx_nxt   = fvidx_r;
    mn_nxt      = mn_r;
    mx_nxt      = mx_r;
    em_v_nxt    = em_v_r;
    em_act_nxt  = em_act_r;
    em_note_nxt = em_note_r;
    em_vel_nxt  = em_vel_r;
    em_last_nxt = em_last_r;
    q_pop       = 1'b0;
    out_ld      = 1'b0;
    mem_re      = 1'b0;
    mem_ra      = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    vwt_en      = 1'b0;
    vwn_en      = 1'b0;
    vw_taken    = 1'b0;
    vw_v        = '0;
    vw_note     = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          n_nxt   = q_cmd.note;
          vel_nxt = q_cmd.vel;
          tgt_nxt = q_cmd.note;
          if (poly_mode) begin
            if (!q_cmd.note_on) begin
              state_nxt = ST_POFF;
            end else if (free_found) begin
              em_v_nxt    = free_idx;
              em_act_nxt  = ACT_ON;
              em_note_nxt = q_cmd.note;
              em_vel_nxt  = q_cmd.vel;
              em_last_nxt = 1'b1;
              vwt_en      = 1'b1;
              vwn_en      = 1'b1;
              vw_taken    = 1'b1;
              vw_v        = free_idx;
              vw_note     = q_cmd.note;
              push_n_nxt  = q_cmd.note;
              push_v_nxt  = free_idx;
              state_nxt   = ST_EMIT;
              ret_nxt     = ST_PUSH;
            end else if (cfg.mode == MODE_STEAL && count_r != '0) begin
              state_nxt = ST_STL_RD;
            end
          end else begin
            state_nxt = ST_SCAN;
            ret_nxt   = q_cmd.note_on ? ST_MON1 : ST_MOFF1;
          end
        end
      end

      ST_SCAN: begin
        if (sp_r < count_r) begin
          mem_re   = 1'b1;
          mem_ra   = sp_r[AW-1:0];
          sp_nxt   = sp_r + 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = sp_r[AW-1:0];
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (rd_note == tgt_r && !fn_r) begin
            fn_nxt   = 1'b1;
            fidx_nxt = pidx_r;
          end
          if (rd_note == tgt_r && rd_voice == cmpv_r && !fnv_r) begin
            fnv_nxt   = 1'b1;
            fvidx_nxt = pidx_r;
          end
          if (rd_note < mn_r) begin
            mn_nxt = rd_note;
          end
          if (rd_note > mx_r) begin
            mx_nxt = rd_note;
          end
        end
        if (sp_r >= count_r && !pv_r) begin
          state_nxt = ret_r;
        end
      end

      ST_REM: begin
        if (rp_r < count_r) begin
          mem_re   = 1'b1;
          mem_ra   = rp_r[AW-1:0];
          pend_nxt = 1'b1;
          pa_nxt   = AW'(rp_r - 1'b1);
          rp_nxt   = rp_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pa_r;
          mem_wd = rd_q;
        end
        if (rp_r >= count_r && !pend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = ret_r;
        end
      end

      ST_PUSH: begin
        if (sh_r != '0) begin
          mem_re   = 1'b1;
          mem_ra   = AW'(sh_r - 1'b1);
          pend_nxt = 1'b1;
          pa_nxt   = sh_r[AW-1:0];
          sh_nxt   = sh_r - 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pa_r;
          mem_wd = rd_q;
        end else if (sh_r == '0) begin
          mem_we    = 1'b1;
          mem_wa    = '0;
          mem_wd    = {push_n_r, push_v_r};
          count_nxt = (count_r >= CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH) : count_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (!out_v_r || out_ch.ready) begin
          out_ld    = 1'b1;
          state_nxt = ret_r;
        end
      end

      ST_STL_RD: begin
        mem_re    = 1'b1;
        mem_ra    = AW'(count_r - 1'b1);
        state_nxt = ST_STL_CHK;
      end

      ST_STL_CHK: begin
        count_nxt = count_r - 1'b1;
        state_nxt = ST_IDLE;
        if (rd_voice != NO_VOICE && {1'b0, rd_voice} < 5'(NUM_VOICES)) begin
          em_v_nxt    = rd_voice;
          em_act_nxt  = ACT_REVOICE;
          em_note_nxt = n_r;
          em_vel_nxt  = vel_r;
          em_last_nxt = 1'b1;
          vwt_en      = 1'b1;
          vwn_en      = 1'b1;
          vw_taken    = 1'b1;
          vw_v        = rd_voice;
          vw_note     = n_r;
          push_n_nxt  = n_r;
          push_v_nxt  = rd_voice;
          state_nxt   = ST_EMIT;
          ret_nxt     = ST_PUSH;
        end
      end

      ST_POFF: begin
        if (!m_found) begin
          state_nxt = ST_IDLE;
        end else begin
          em_v_nxt    = m_idx;
          em_act_nxt  = ACT_OFF;
          em_note_nxt = n_r;
          em_vel_nxt  = vel_r;
          em_last_nxt = !m_more;
          vwt_en      = 1'b1;
          vwn_en      = 1'b1;
          vw_v        = m_idx;
          cmpv_nxt    = m_idx;
          state_nxt   = ST_EMIT;
          ret_nxt     = ST_POFF_S;
        end
      end

      ST_POFF_S: begin
        state_nxt = ST_SCAN;
        ret_nxt   = ST_POFF_RM;
      end

      ST_POFF_RM: begin
        state_nxt = ST_POFF;
        if (fnv_r) begin
          rem_idx_nxt = CW'(fvidx_r);
          state_nxt   = ST_REM;
          ret_nxt     = ST_POFF;
        end
      end

      ST_MON1: begin
        if (count_r != '0 && (hi_mode ? (n_r <= mx_r) : (n_r >= mn_r))) begin
          push_n_nxt = n_r;
          push_v_nxt = NO_VOICE;
          state_nxt  = ST_PUSH;
        end else if (count_r == '0) begin
          push_n_nxt = n_r;
          if (!any_en) begin
            push_v_nxt = NO_VOICE;
            state_nxt  = ST_PUSH;
          end else begin
            mv_nxt      = hi_en;
            em_v_nxt    = hi_en;
            em_act_nxt  = ACT_ON;
            em_note_nxt = n_r;
            em_vel_nxt  = vel_r;
            em_last_nxt = 1'b1;
            vwt_en      = 1'b1;
            vwn_en      = 1'b1;
            vw_taken    = 1'b1;
            vw_v        = hi_en;
            vw_note     = n_r;
            push_v_nxt  = hi_en;
            state_nxt   = ST_EMIT;
            ret_nxt     = ST_PUSH;
          end
        end else begin
          tgt_nxt   = ext;
          cur_nxt   = ext;
          state_nxt = ST_SCAN;
          ret_nxt   = ST_MON2;
        end
      end

      ST_MON2: begin
        if (fn_r) begin
          mem_we = 1'b1;
          mem_wa = fidx_r;
          mem_wd = {cur_r, NO_VOICE};
        end
        em_v_nxt    = mv_r;
        em_act_nxt  = ACT_RETUNE;
        em_note_nxt = n_r;
        em_vel_nxt  = 7'd0;
        em_last_nxt = 1'b1;
        vwn_en      = 1'b1;
        vw_v        = mv_r;
        vw_note     = n_r;
        push_n_nxt  = n_r;
        push_v_nxt  = mv_r;
        state_nxt   = ST_EMIT;
        ret_nxt     = ST_PUSH;
      end

      ST_MOFF1: begin
        state_nxt = ST_IDLE;
        if (fn_r) begin
          cur_nxt     = ext;
          rem_idx_nxt = CW'(fidx_r);
          state_nxt   = ST_REM;
          ret_nxt     = ST_MOFF2;
        end
      end

      ST_MOFF2: begin
        if (n_r != cur_r) begin
          state_nxt = ST_IDLE;
        end else if (count_r != '0) begin
          state_nxt = ST_SCAN;
          ret_nxt   = ST_MOFF3;
        end else begin
          em_v_nxt    = mv_r;
          em_act_nxt  = ACT_OFF;
          em_note_nxt = n_r;
          em_vel_nxt  = vel_r;
          em_last_nxt = 1'b1;
          vwt_en      = 1'b1;
          vwn_en      = 1'b1;
          vw_v        = mv_r;
          state_nxt   = ST_EMIT;
          ret_nxt     = ST_IDLE;
        end
      end

      ST_MOFF3: begin
        tgt_nxt   = ext;
        cur_nxt   = ext;
        state_nxt = ST_SCAN;
        ret_nxt   = ST_MOFF4;
      end

      ST_MOFF4: begin
        if (fn_r) begin
          mem_we = 1'b1;
          mem_wa = fidx_r;
          mem_wd = {cur_r, mv_r};
        end
        em_v_nxt    = mv_r;
        em_act_nxt  = ACT_RETUNE;
        em_note_nxt = cur_r;
        em_vel_nxt  = 7'd0;
        em_last_nxt = 1'b1;
        vwn_en      = 1'b1;
        vw_v        = mv_r;
        vw_note     = cur_r;
        state_nxt   = ST_EMIT;
        ret_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (state_nxt != state_r) begin
      if (state_nxt == ST_SCAN) begin
        sp_nxt  = '0;
        pv_nxt  = 1'b0;
        fn_nxt  = 1'b0;
        fnv_nxt = 1'b0;
        mn_nxt  = 7'h7F;
        mx_nxt  = 7'h00;
      end else if (state_nxt == ST_REM) begin
        rp_nxt   = rem_idx_nxt + 1'b1;
        pend_nxt = 1'b0;
      end else if (state_nxt == ST_PUSH) begin
        sh_nxt   = (count_r >= CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH - 1) : count_r;
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      count_r <= '0;
      mv_r    <= '0;
      out_v_r <= 1'b0;
      taken_r <= '0;
      for (int c = 0; c < NUM_VOICES; c++) begin
        vnote_r[c] <= 7'd0;
      end
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      count_r <= count_nxt;
      mv_r    <= mv_nxt;
      if (out_ld) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (vwt_en) begin
        taken_r[vw_v[VW-1:0]] <= vw_taken;
      end
      if (vwn_en) begin
        vnote_r[vw_v[VW-1:0]] <= vw_note;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    vel_r     <= vel_nxt;
    tgt_r     <= tgt_nxt;
    cur_r     <= cur_nxt;
    cmpv_r    <= cmpv_nxt;
    push_n_r  <= push_n_nxt;
    push_v_r  <= push_v_nxt;
    rem_idx_r <= rem_idx_nxt;
    sh_r      <= sh_nxt;
    rp_r      <= rp_nxt;
    sp_r      <= sp_nxt;
    pend_r    <= pend_nxt;
    pa_r      <= pa_nxt;
    pv_r      <= pv_nxt;
    pidx_r    <= pidx_nxt;
    fn_r      <= fn_nxt;
    fidx_r    <= fidx_nxt;
    fnv_r     <= fnv_nxt;
    fvidx_r   <= fvidx_nxt;
    mn_r      <= mn_nxt;
    mx_r      <= mx_nxt;
    em_v_r    <= em_v_nxt;
    em_act_r  <= em_act_nxt;
    em_note_r <= em_note_nxt;
    em_vel_r  <= em_vel_nxt;
    em_last_r <= em_last_nxt;
    if (out_ld) begin
      out_v_idx_r <= em_v_r;
      out_act_r   <= em_act_r;
      out_note_r  <= em_note_r;
      out_vel_r   <= em_vel_r;
      out_last_r  <= em_last_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.voice_index  = out_v_idx_r[2:0];
  assign out_ch.voice_action = out_act_r;
  assign out_ch.note_number  = out_note_r;
  assign out_ch.velocity     = out_vel_r;
  assign out_ch.last_command = out_last_r;

  `MVA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(STACK_DEPTH), "stack count above depth")
  `MVA_ASSERT_NOW(a_scan_ptr, state_r == ST_SCAN, sp_r <= count_r, "scan pointer past stack top")
  `MVA_ASSERT_NEXT(a_push_grows, state_r == ST_PUSH && !pend_r && sh_r == '0, count_r != '0, "stack empty after push")

endmodule

FILE: hdl/midi_voice_allocator_unit.sv
// MIDI voice allocator: classifies note messages, tracks held notes and issues
// voice generator commands in four allocation modes. Top level; depends on
// mva_pkg, mva_if, mva_front, mva_queue and mva_back.
//
// One MIDI message per transfer on in_msg; each produces zero or more voice
// commands on out_cmd, the final one flagged by last_command. Messages are
// classified at once and wait in a four-entry queue; the sequencer then works
// on one message at a time. Its work is set by the note stack memory, read one
// entry per cycle: a polyphonic note on pushes the note, which shifts the stack,
// a monophonic note on or off scans the stack before it pushes or removes, and
// a polyphonic note off scans and removes once for each voice it releases. The
// stack holds at most STACK_DEPTH notes. A stalled out_cmd holds the sequencer;
// the queue keeps taking messages until it is full. Configuration is written
// through cfg_we, cfg_idx and cfg_wdata; the user must do so only while no
// message is in flight, as the block itself does not enforce this.
module midi_voice_allocator_unit #(
  parameter int NUM_VOICES  = 8,
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_wdata,
  mva_in_if.sink     in_msg,
  mva_out_if.source  out_cmd
);
  import mva_pkg::*;

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_SATURATE;
      cfg_r.mask <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ALLOC_MODE: cfg_r.mode <= mode_t'(cfg_wdata[1:0]);
        CFG_VOICE_MASK: cfg_r.mask <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  mva_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_msg),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  mva_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  mva_back #(
    .NUM_VOICES  (NUM_VOICES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_cmd)
  );

endmodule

FILE: tb/sv/mva_cmd_checker.sv
`timescale 1ns / 1ps
// Voice command checker: watches the message, command and register channels,
// predicts the voice commands of each message and compares them. Needs mva_pkg, mva_if.
module mva_cmd_checker
  import mva_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_wdata,
  mva_in_if          msg_ch,
  mva_out_if         cmd_ch,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [2:0] voice;
    act_t       action;
    logic [6:0] note;
    logic [6:0] vel;
    logic       last;
  } voice_cmd_t;

  voice_cmd_t awaited_cmds[$];
  voice_cmd_t msg_cmds[$];

  mode_t      alloc_mode;
  logic [7:0] voice_mask;
  logic [6:0] held_note[16];
  logic [3:0] held_voice[16];
  int         held_count;
  bit         voice_busy[8];
  logic [6:0] voice_pitch[8];
  logic [2:0] mono_voice;
  logic [7:0] run_status;

  assign pending = awaited_cmds.size();

  task automatic report(input string what);
    $display("%0t: voice command mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic issue(input int v, input act_t a, input int n, input int vel);
    voice_cmd_t c;
    c.voice = v[2:0];
    c.action = a;
    c.note = n[6:0];
    c.vel = vel[6:0];
    c.last = 1'b0;
    if (msg_cmds.size() < 8) msg_cmds.push_back(c);
  endtask

  function automatic bit voice_usable(input int c);
    return c < 8 && voice_mask[c];
  endfunction

  task automatic hold_note(input int n, input logic [3:0] v);
    if (held_count >= 16) held_count = 15;
    for (int i = held_count; i > 0; i--) begin
      held_note[i] = held_note[i-1];
      held_voice[i] = held_voice[i-1];
    end
    held_note[0] = n[6:0];
    held_voice[0] = v;
    held_count++;
  endtask

  task automatic drop_note(input int i);
    if (i >= held_count) return;
    for (int j = i; j < held_count - 1; j++) begin
      held_note[j] = held_note[j+1];
      held_voice[j] = held_voice[j+1];
    end
    held_count--;
    held_voice[held_count] = NO_VOICE;
  endtask

  function automatic int find_held(input int n);
    for (int i = 0; i < held_count; i++)
      if (held_note[i] == n) return i;
    return -1;
  endfunction

  function automatic int outer_note(input bit hi);
    int r;
    r = hi ? -1 : 128;
    for (int i = 0; i < held_count; i++)
      if (hi ? (int'(held_note[i]) > r) : (int'(held_note[i]) < r)) r = held_note[i];
    return r;
  endfunction

  task automatic start_note(input int n, input int vel);
    bit hi, found;
    int cur, i;
    logic [3:0] v;
    if (alloc_mode == MODE_SATURATE || alloc_mode == MODE_STEAL) begin
      for (int c = 0; c < 8; c++) begin
        if (voice_usable(c) && !voice_busy[c]) begin
          issue(c, ACT_ON, n, vel);
          voice_busy[c] = 1;
          voice_pitch[c] = n[6:0];
          hold_note(n, 4'(c));
          return;
        end
      end
      if (alloc_mode == MODE_STEAL && held_count > 0) begin
        v = held_voice[held_count-1];
        drop_note(held_count - 1);
        if (v != NO_VOICE && v < 8) begin
          issue(v, ACT_REVOICE, n, vel);
          voice_busy[v] = 1;
          voice_pitch[v] = n[6:0];
          hold_note(n, v);
        end
      end
    end else begin
      hi = alloc_mode == MODE_MONO_HIGH;
      cur = outer_note(hi);
      if (!(hi ? (n > cur) : (n < cur))) begin
        hold_note(n, NO_VOICE);
        return;
      end
      if (held_count == 0) begin
        found = 0;
        for (int c = 0; c < 8; c++)
          if (voice_usable(c)) begin
            mono_voice = c[2:0];
            found = 1;
          end
        if (!found) begin
          hold_note(n, NO_VOICE);
          return;
        end
        issue(mono_voice, ACT_ON, n, vel);
        voice_busy[mono_voice] = 1;
        voice_pitch[mono_voice] = n[6:0];
        hold_note(n, {1'b0, mono_voice});
      end else begin
        i = find_held(cur);
        issue(mono_voice, ACT_RETUNE, n, 0);
        if (i >= 0) held_voice[i] = NO_VOICE;
        voice_pitch[mono_voice] = n[6:0];
        hold_note(n, {1'b0, mono_voice});
      end
    end
  endtask

  task automatic stop_note(input int n, input int vel);
    bit hi;
    int cur, k, nxt, j;
    if (alloc_mode == MODE_SATURATE || alloc_mode == MODE_STEAL) begin
      for (int c = 0; c < 8; c++) begin
        if (voice_usable(c) && voice_busy[c] && voice_pitch[c] == n) begin
          issue(c, ACT_OFF, n, vel);
          voice_busy[c] = 0;
          voice_pitch[c] = 0;
          for (int i = 0; i < held_count; i++)
            if (held_note[i] == n && held_voice[i] == c) begin
              drop_note(i);
              break;
            end
        end
      end
    end else begin
      hi = alloc_mode == MODE_MONO_HIGH;
      cur = outer_note(hi);
      k = find_held(n);
      if (k < 0) return;
      drop_note(k);
      if (n != cur) return;
      if (held_count > 0) begin
        nxt = outer_note(hi);
        j = find_held(nxt);
        if (j >= 0) held_voice[j] = {1'b0, mono_voice};
        issue(mono_voice, ACT_RETUNE, nxt, 0);
        voice_pitch[mono_voice] = nxt[6:0];
      end else begin
        issue(mono_voice, ACT_OFF, n, vel);
        voice_busy[mono_voice] = 0;
        voice_pitch[mono_voice] = 0;
      end
    end
  endtask

  task automatic predict_msg(input logic [7:0] b0, input logic [6:0] b1,
                             input logic [6:0] b2, input logic [2:0] cnt);
    logic [7:0] hi4;
    hi4 = b0 & STATUS_MASK;
    msg_cmds.delete();
    if (hi4 == STATUS_NOTE_ON && cnt == 3) begin
      run_status = STATUS_NOTE_ON;
      if (b2 != 0) start_note(b1, b2);
      else stop_note(b1, 0);
    end else if (hi4 == STATUS_NOTE_OFF && cnt == 3) begin
      run_status = STATUS_NOTE_OFF;
      stop_note(b1, b2);
    end else if (b0[7]) begin
      run_status = hi4;
    end else if (cnt == 2) begin
      if (run_status == STATUS_NOTE_ON && b1 != 0) start_note(b0, b1);
      else if (run_status == STATUS_NOTE_ON || run_status == STATUS_NOTE_OFF)
        stop_note(b0, b1);
    end
    if (msg_cmds.size() > 0) msg_cmds[msg_cmds.size()-1].last = 1'b1;
    foreach (msg_cmds[i]) awaited_cmds.push_back(msg_cmds[i]);
  endtask

  always @(posedge clk) begin
    voice_cmd_t want;
    if (!rst_n) begin
      alloc_mode = MODE_SATURATE;
      voice_mask = 8'hFF;
      for (int i = 0; i < 16; i++) held_voice[i] = NO_VOICE;
      held_count = 0;
      for (int c = 0; c < 8; c++) begin
        voice_busy[c] = 0;
        voice_pitch[c] = 0;
      end
      mono_voice = 0;
      run_status = 0;
      awaited_cmds.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_ALLOC_MODE) alloc_mode = mode_t'(cfg_wdata[1:0]);
        else voice_mask = cfg_wdata;
      end
      if (msg_ch.valid && msg_ch.ready)
        predict_msg(msg_ch.first_byte, msg_ch.second_byte, msg_ch.third_byte,
                    msg_ch.byte_count);
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (awaited_cmds.size() == 0) begin
          report("command transfer with nothing expected");
        end else begin
          want = awaited_cmds.pop_front();
          if (cmd_ch.voice_index !== want.voice)
            report($sformatf("voice_index %0d, expected %0d", cmd_ch.voice_index, want.voice));
          if (cmd_ch.voice_action !== want.action)
            report($sformatf("voice_action %0d, expected %0d", cmd_ch.voice_action,
                             want.action));
          if (cmd_ch.note_number !== want.note)
            report($sformatf("note_number %0d, expected %0d", cmd_ch.note_number, want.note));
          if (cmd_ch.velocity !== want.vel)
            report($sformatf("velocity %0d, expected %0d", cmd_ch.velocity, want.vel));
          if (cmd_ch.last_command !== want.last)
            report($sformatf("last_command %0d, expected %0d", cmd_ch.last_command,
                             want.last));
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

FILE: tb/sv/midi_voice_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Top of the voice allocator testbench: clock, reset, message and register
// stimulus, command back-pressure and the verdict. Needs mva_pkg, mva_if, mva_cmd_checker.
module midi_voice_allocator_unit_tb;
  import mva_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         stall_left;
  int         calm_left;

  mva_in_if  msg_ch();
  mva_out_if cmd_ch();

  midi_voice_allocator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_msg   (msg_ch.sink),
    .out_cmd  (cmd_ch.source)
  );

  mva_cmd_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .msg_ch    (msg_ch),
    .cmd_ch    (cmd_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.ready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else if (calm_left > 0) begin
      calm_left--;
      cmd_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= 1'b1;
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 200);
      else if ($urandom_range(0, 2) == 0)
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_msg(input logic [7:0] b0, input logic [6:0] b1,
                          input logic [6:0] b2, input logic [2:0] cnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.first_byte <= b0;
    msg_ch.second_byte <= b1;
    msg_ch.third_byte <= b2;
    msg_ch.byte_count <= cnt;
    do @(posedge clk); while (!msg_ch.ready);
  endtask

  task automatic drain();
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [6:0] pick_note();
    return ($urandom_range(0, 3) != 0) ? 7'($urandom_range(40, 60)) : 7'($urandom_range(0, 127));
  endfunction

  task automatic send_random();
    int r;
    logic [3:0] ch;
    r = $urandom_range(0, 99);
    ch = 4'($urandom_range(0, 15));
    if (r < 42) send_msg({4'h9, ch}, pick_note(), 7'($urandom_range(1, 127)), 3'd3);
    else if (r < 62) send_msg({4'h8, ch}, pick_note(), 7'($urandom_range(0, 127)), 3'd3);
    else if (r < 70) send_msg({4'h9, ch}, pick_note(), 7'd0, 3'd3);
    else if (r < 88) send_msg({1'b0, pick_note()}, 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)), 3'd2);
    else send_msg(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)), 3'($urandom_range(0, 4)));
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_ALLOC_MODE;
    cfg_wdata <= 8'h00;
    msg_ch.valid <= 1'b0;
    msg_ch.first_byte <= 8'h00;
    msg_ch.second_byte <= 7'h00;
    msg_ch.third_byte <= 7'h00;
    msg_ch.byte_count <= 3'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_ALLOC_MODE, 8'(MODE_SATURATE));
    write_reg(CFG_VOICE_MASK, 8'hFF);
    send_msg(8'h90, 7'd127, 7'd127, 3'd3);
    send_msg(8'h9F, 7'd0, 7'd1, 3'd3);
    send_msg(8'h91, 7'd60, 7'd64, 3'd3);
    send_msg(8'h90, 7'd60, 7'd0, 3'd3);
    send_msg(8'h8F, 7'd127, 7'd127, 3'd3);
    send_msg(8'h80, 7'd99, 7'd5, 3'd3);
    send_msg(8'h90, 7'd70, 7'd10, 3'd3);
    send_msg(8'h45, 7'd30, 7'd0, 3'd2);
    send_msg(8'h45, 7'd0, 7'd0, 3'd2);
    send_msg(8'h7F, 7'd127, 7'd127, 3'd2);
    send_msg(8'hF0, 7'd0, 7'd0, 3'd1);
    send_msg(8'h46, 7'd20, 7'd0, 3'd2);
    send_msg(8'h80, 7'd70, 7'd0, 3'd3);
    send_msg(8'h46, 7'd33, 7'd0, 3'd2);
    send_msg(8'h90, 7'd1, 7'd1, 3'd4);
    send_msg(8'h90, 7'd1, 7'd1, 3'd0);
    send_msg(8'h00, 7'd0, 7'd0, 3'd4);
    send_msg(8'hFF, 7'd127, 7'd127, 3'd7);
    drain();

    write_reg(CFG_ALLOC_MODE, 8'(MODE_STEAL));
    for (int i = 0; i < 20; i++) send_msg(8'h90, 7'(10 + i), 7'd100, 3'd3);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0: write_reg(CFG_ALLOC_MODE, 8'(MODE_SATURATE));
        1: write_reg(CFG_ALLOC_MODE, 8'(MODE_STEAL));
        2: write_reg(CFG_ALLOC_MODE, 8'(MODE_MONO_LOW));
        default: write_reg(CFG_ALLOC_MODE, 8'(MODE_MONO_HIGH));
      endcase
      case (p)
        5: write_reg(CFG_VOICE_MASK, 8'h00);
        6: write_reg(CFG_VOICE_MASK, 8'h80);
        7: write_reg(CFG_VOICE_MASK, 8'($urandom_range(0, 255)));
        default: write_reg(CFG_VOICE_MASK, 8'hFF);
      endcase
      for (int i = 0; i < 20; i++) send_random();
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
